/* src/cls_pkg.sv */
`default_nettype none
package cls_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ACC_WIDTH   = 48;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int LAG_W       = 13;
  localparam int REQ_W       = 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > LAG_W) ? CNT_W : LAG_W;

  localparam logic [LAG_W-1:0] MAX_LAG_RESET = LAG_W'(4096);

  localparam logic [REQ_W-1:0] REQ_LOAD_REC = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_LOAD_REF = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_RUN      = REQ_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LAG_START,
    ST_ISSUE,
    ST_DRAIN,
    ST_COMPARE,
    ST_FINISH
  } cls_state_t;

  typedef struct packed {
    logic setup;
    logic lag_start;
    logic issue;
    logic compare;
    logic finish;
  } cls_cmd_t;

  typedef struct packed {
    logic empty_run;
    logic i_done;
    logic pipe_idle;
    logic last_lag;
  } cls_stat_t;

endpackage
`default_nettype wire

/* src/cls_ram.sv */
`default_nettype none
module cls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/cls_ctrl.sv */
`default_nettype none
module cls_ctrl
  import cls_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      run_start,
  input  wire cls_stat_t stat,
  output cls_cmd_t       cmd,
  output logic           busy
);

  cls_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_start) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = stat.empty_run ? ST_FINISH : ST_LAG_START;
      end
      ST_LAG_START: begin
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (stat.i_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_idle) state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_nxt = stat.last_lag ? ST_FINISH : ST_LAG_START;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE:      busy          = 1'b0;
      ST_SETUP:     cmd.setup     = 1'b1;
      ST_LAG_START: cmd.lag_start = 1'b1;
      ST_ISSUE:     cmd.issue     = 1'b1;
      ST_DRAIN:     cmd           = '0;
      ST_COMPARE:   cmd.compare   = 1'b1;
      ST_FINISH:    cmd.finish    = 1'b1;
      default:      busy          = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

/* src/cls_dp.sv */
`default_nettype none
module cls_dp
  import cls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [LAG_W-1:0]    cfg_wdata,
  input  wire logic                in_acc,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire cls_cmd_t            cmd,
  output cls_stat_t                stat,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [LAG_W-1:0]         out_best_lag,
  output logic                     out_samples_dropped
);

  localparam logic signed [ACC_WIDTH-1:0] START_BEST = ACC_WIDTH'(-(64'sd1 <<< 30));
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX    = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN    = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [CNT_W-1:0]            FULL_CNT   = CNT_W'(STORE_DEPTH);

  logic [LAG_W-1:0] max_lag_r;
  logic [CNT_W-1:0] rec_cnt_r, ref_cnt_r;
  logic             flag_r;

  logic [LIM_W-1:0] limit_r, lag_r;
  logic [CNT_W-1:0] common_r, n_r, i_r;
  logic             rd_v_r, mul_v_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [ACC_WIDTH-1:0] acc_r, best_r;
  logic [LIM_W-1:0] best_lag_r;
  logic             out_valid_r, out_drop_r;
  logic [LAG_W-1:0] out_lag_r;

  logic load_rec, load_ref, rec_full, ref_full, issue_now;
  logic [SAMPLE_W-1:0] rec_q, ref_q;
  logic [ADDR_W-1:0]   rec_raddr, ref_raddr;
  logic [LIM_W-1:0]    lim_a, lim_b, rec_m1, ref_ext;
  logic [CNT_W-1:0]    common_nxt;
  logic signed [ACC_WIDTH:0] sum_w;
  logic signed [ACC_WIDTH-1:0] acc_sat;

  assign rec_full = (rec_cnt_r == FULL_CNT);
  assign ref_full = (ref_cnt_r == FULL_CNT);
  assign load_rec = in_acc && (req_type == REQ_LOAD_REC);
  assign load_ref = in_acc && (req_type == REQ_LOAD_REF);

  assign rec_raddr = ADDR_W'(lag_r + LIM_W'(i_r));
  assign ref_raddr = i_r[ADDR_W-1:0];

  cls_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (load_rec && !rec_full),
    .waddr (rec_cnt_r[ADDR_W-1:0]),
    .wdata (sample),
    .raddr (rec_raddr),
    .rdata (rec_q)
  );

  cls_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (load_ref && !ref_full),
    .waddr (ref_cnt_r[ADDR_W-1:0]),
    .wdata (sample),
    .raddr (ref_raddr),
    .rdata (ref_q)
  );

  always_comb begin
    ref_ext    = LIM_W'(ref_cnt_r);
    rec_m1     = LIM_W'(rec_cnt_r) - LIM_W'(1);
    lim_a      = LIM_W'(max_lag_r);
    lim_b      = (lim_a > rec_m1) ? rec_m1 : lim_a;
    if (lim_b > ref_ext) lim_b = ref_ext;
    common_nxt = (rec_cnt_r < ref_cnt_r) ? rec_cnt_r : ref_cnt_r;
  end

  assign issue_now = cmd.issue && (i_r != n_r);

  always_comb begin
    sum_w = {acc_r[ACC_WIDTH-1], acc_r} + (ACC_WIDTH + 1)'(prod_r);
    if (sum_w[ACC_WIDTH] != sum_w[ACC_WIDTH-1]) begin
      acc_sat = sum_w[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum_w[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    stat.empty_run = (rec_cnt_r == '0) || (ref_cnt_r == '0);
    stat.i_done    = (i_r == n_r);
    stat.pipe_idle = !rd_v_r && !mul_v_r;
    stat.last_lag  = (lag_r == limit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lag_r   <= MAX_LAG_RESET;
      rec_cnt_r   <= '0;
      ref_cnt_r   <= '0;
      flag_r      <= 1'b0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_lag_r <= cfg_wdata;
      if (load_rec) begin
        if (rec_full) flag_r <= 1'b1;
        else rec_cnt_r <= rec_cnt_r + CNT_W'(1);
      end
      if (load_ref) begin
        if (ref_full) flag_r <= 1'b1;
        else ref_cnt_r <= ref_cnt_r + CNT_W'(1);
      end
      rd_v_r  <= issue_now;
      mul_v_r <= rd_v_r;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        rec_cnt_r   <= '0;
        ref_cnt_r   <= '0;
        flag_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      limit_r    <= lim_b;
      common_r   <= common_nxt;
      lag_r      <= '0;
      best_r     <= START_BEST;
      best_lag_r <= '0;
    end
    if (cmd.lag_start) begin
      acc_r <= '0;
      i_r   <= '0;
      n_r   <= (lag_r < LIM_W'(common_r)) ? CNT_W'(LIM_W'(common_r) - lag_r) : '0;
    end
    if (issue_now) i_r <= i_r + CNT_W'(1);
    if (rd_v_r) prod_r <= $signed(rec_q) * $signed(ref_q);
    if (mul_v_r) acc_r <= acc_sat;
    if (cmd.compare) begin
      if (acc_r > best_r) begin
        best_r     <= acc_r;
        best_lag_r <= lag_r;
      end
      lag_r <= lag_r + LIM_W'(1);
    end
    if (cmd.finish) begin
      out_lag_r  <= stat.empty_run ? '0 : LAG_W'(best_lag_r);
      out_drop_r <= flag_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_best_lag        = out_lag_r;
  assign out_samples_dropped = out_drop_r;

endmodule
`default_nettype wire

/* src/correlation_lag_search_core.sv */
`default_nettype none
// Each load beat writes the next free entry of the recorded or reference
// store; a load into a full store is dropped and reported with the next result.
// A run beat searches lags from 0 to the clamped limit (or none if either store
// is empty) with one multiply-accumulate unit fed by the read ports of the two
// sample memories, then answers with one result beat and clears both counts.
// The input stalls while a run is in progress, and a new run beat also stalls
// while the previous result still waits to be taken.
module correlation_lag_search_core
  import cls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [LAG_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [LAG_W-1:0]         out_best_lag,
  output logic                     out_samples_dropped
);

  cls_cmd_t  cmd;
  cls_stat_t stat;
  logic      busy, in_acc;

  assign in_stall = busy || (out_valid && (in_req_type == REQ_RUN));
  assign in_acc   = in_valid && !in_stall;

  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_start (in_acc && (in_req_type == REQ_RUN)),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  cls_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_acc              (in_acc),
    .req_type            (in_req_type),
    .sample              (in_sample),
    .cmd                 (cmd),
    .stat                (stat),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_best_lag        (out_best_lag),
    .out_samples_dropped (out_samples_dropped)
  );

endmodule
`default_nettype wire

/* src/cls_checker.sv */
`default_nettype none
module cls_checker
  import cls_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic [REQ_W-1:0]    in_req_type,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [LAG_W-1:0]    out_best_lag,
  input wire logic                out_samples_dropped
);

  logic run_beat;
  assign run_beat = in_valid && !in_stall && (in_req_type == REQ_RUN);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_lag)
      && $stable(out_samples_dropped))
    else $error("result beat changed while stalled");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_beat |=> in_stall)
    else $error("input not stalled after a run beat");

  a_run_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    run_beat |-> !out_valid || !out_stall)
    else $error("run accepted while a result is held");

  a_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_best_lag) < STORE_DEPTH))
    else $error("result lag beyond store depth");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind correlation_lag_search_core cls_checker u_cls_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_req_type         (in_req_type),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_best_lag        (out_best_lag),
  .out_samples_dropped (out_samples_dropped)
);
`default_nettype wire
